// ----- hdl/sai_pkg.sv -----
`timescale 1ns / 1ps
package sai_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int DIV_RW     = 50;
  localparam int PROD_W     = 66;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd3;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [16:0]        entry_fraction;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_t;

  typedef struct packed {
    logic        rej;
    logic [32:0] a;
    logic [32:0] b;
    logic [32:0] den;
  } lane_t;

  typedef struct packed {
    logic [32:0] n;
    logic [32:0] d;
  } rat_t;

endpackage

// ----- hdl/segment_aabb_intersect_top.sv -----
// throughput: one segment per cycle, busy stays low; the receiver cannot stall
// the pipe depth is set by the 17-stage rounded divider after the lane merge
// reset (rst_n low, synchronous) empties the pipe and loads the box at center
// (1.0, 1.0, 1.0) with half width 1.0
`timescale 1ns / 1ps
module segment_aabb_intersect_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sai_pkg::in_t  in_data,
  output logic          out_valid,
  output sai_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        hw_r;
  logic               acc;
  logic               v1_r;
  sai_pkg::in_t       seg1_r;
  sai_pkg::lane_t     lx, ly, lz;
  logic               mv, mhit, dv, dhit;
  sai_pkg::rat_t      mlo;
  sai_pkg::in_t       mseg, dseg;
  logic [16:0]        dq;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 32'sd65536;
      cy_r <= 32'sd65536;
      cz_r <= 32'sd65536;
      hw_r <= 31'd65536;
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sai_pkg::REG_CENTER_X:   cx_r <= cfg_data;
          sai_pkg::REG_CENTER_Y:   cy_r <= cfg_data;
          sai_pkg::REG_CENTER_Z:   cz_r <= cfg_data;
          sai_pkg::REG_HALF_WIDTH: hw_r <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
    seg1_r <= in_data;
  end

  sai_lane u_lane_x (.clk(clk), .s(in_data.start_x), .e(in_data.end_x), .c(cx_r),
                     .hw(hw_r), .lane_r(lx));
  sai_lane u_lane_y (.clk(clk), .s(in_data.start_y), .e(in_data.end_y), .c(cy_r),
                     .hw(hw_r), .lane_r(ly));
  sai_lane u_lane_z (.clk(clk), .s(in_data.start_z), .e(in_data.end_z), .c(cz_r),
                     .hw(hw_r), .lane_r(lz));

  sai_merge u_merge (
    .clk(clk), .rst_n(rst_n), .in_v(v1_r), .in_seg(seg1_r),
    .lx(lx), .ly(ly), .lz(lz),
    .out_v(mv), .out_hit(mhit), .out_lo(mlo), .out_seg(mseg)
  );

  sai_div u_div (
    .clk(clk), .rst_n(rst_n), .in_v(mv), .in_hit(mhit), .in_ratio(mlo),
    .in_seg(mseg), .out_v(dv), .out_hit(dhit), .out_q(dq), .out_seg(dseg)
  );

  sai_point u_point (
    .clk(clk), .rst_n(rst_n), .in_v(dv), .in_hit(dhit), .in_t16(dq),
    .in_seg(dseg), .out_valid(out_valid), .out_data(out_data)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##24 out_valid)
    else $error("result beat missing after fixed latency");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_fraction <= 17'd65536)
    else $error("entry fraction above one");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.entry_fraction == 17'd0 &&
      out_data.point_x == 32'sd0 && out_data.point_y == 32'sd0 &&
      out_data.point_z == 32'sd0)
    else $error("miss beat carries nonzero fields");
`endif

endmodule

// ----- hdl/sai_lane.sv -----
`timescale 1ns / 1ps
module sai_lane (
  input  logic                clk,
  input  logic signed [31:0]  s,
  input  logic signed [31:0]  e,
  input  logic signed [31:0]  c,
  input  logic [30:0]         hw,
  output sai_pkg::lane_t      lane_r
);

  logic signed [34:0] d, near_off, far_off, an, bn, den;
  sai_pkg::lane_t lane_nxt;

  always_comb begin
    d        = 35'(e) - 35'(s);
    near_off = 35'(c) - $signed({4'b0, hw}) - 35'(s);
    far_off  = 35'(c) + $signed({4'b0, hw}) - 35'(s);
    if (d > 0) begin
      an  = near_off;
      bn  = far_off;
      den = d;
    end else begin
      an  = -far_off;
      bn  = -near_off;
      den = -d;
    end
    if (d == 0) begin
      lane_nxt.rej = !(near_off <= 0 && far_off >= 0);
      lane_nxt.a   = 33'd0;
      lane_nxt.b   = 33'd1;
      lane_nxt.den = 33'd1;
    end else begin
      lane_nxt.rej = (bn < 0) || (an > den);
      lane_nxt.a   = (an < 0) ? 33'd0 : an[32:0];
      lane_nxt.b   = (bn > den) ? den[32:0] : bn[32:0];
      lane_nxt.den = den[32:0];
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

endmodule

// ----- hdl/sai_merge.sv -----
`timescale 1ns / 1ps
module sai_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  sai_pkg::in_t    in_seg,
  input  sai_pkg::lane_t  lx,
  input  sai_pkg::lane_t  ly,
  input  sai_pkg::lane_t  lz,
  output logic            out_v,
  output logic            out_hit,
  output sai_pkg::rat_t   out_lo,
  output sai_pkg::in_t    out_seg
);

  localparam int PW = sai_pkg::PROD_W;

  // stage 1: cross products of x and y
  logic v1_r, miss1_r;
  sai_pkg::in_t seg1_r;
  sai_pkg::rat_t lox1_r, loy1_r, hix1_r, hiy1_r, loz1_r, hiz1_r;
  logic [PW-1:0] pxy1_r, pyx1_r, qxy1_r, qyx1_r;

  // stage 2: fold in z
  logic v2_r, miss2_r;
  sai_pkg::in_t seg2_r;
  sai_pkg::rat_t lo2_r, hi2_r, loz2_r, hiz2_r;
  logic [PW-1:0] plz2_r, pzl2_r, qhz2_r, qzh2_r;
  sai_pkg::rat_t lo2_nxt, hi2_nxt;

  // stage 3: lo against hi
  logic v3_r, miss3_r;
  sai_pkg::in_t seg3_r;
  sai_pkg::rat_t lo3_r;
  logic [PW-1:0] plh3_r, phl3_r;
  sai_pkg::rat_t lo3_nxt, hi3_nxt;

  // stage 4
  logic v4_r, hit4_r;
  sai_pkg::in_t seg4_r;
  sai_pkg::rat_t lo4_r;

  always_comb begin
    lo2_nxt = (pyx1_r > pxy1_r) ? loy1_r : lox1_r;
    hi2_nxt = (qyx1_r < qxy1_r) ? hiy1_r : hix1_r;
    lo3_nxt = (pzl2_r > plz2_r) ? loz2_r : lo2_r;
    hi3_nxt = (qzh2_r < qhz2_r) ? hiz2_r : hi2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    miss1_r <= lx.rej || ly.rej || lz.rej;
    seg1_r  <= in_seg;
    lox1_r  <= '{n: lx.a, d: lx.den};
    loy1_r  <= '{n: ly.a, d: ly.den};
    loz1_r  <= '{n: lz.a, d: lz.den};
    hix1_r  <= '{n: lx.b, d: lx.den};
    hiy1_r  <= '{n: ly.b, d: ly.den};
    hiz1_r  <= '{n: lz.b, d: lz.den};
    pxy1_r  <= PW'(lx.a) * PW'(ly.den);
    pyx1_r  <= PW'(ly.a) * PW'(lx.den);
    qxy1_r  <= PW'(lx.b) * PW'(ly.den);
    qyx1_r  <= PW'(ly.b) * PW'(lx.den);

    miss2_r <= miss1_r;
    seg2_r  <= seg1_r;
    lo2_r   <= lo2_nxt;
    hi2_r   <= hi2_nxt;
    loz2_r  <= loz1_r;
    hiz2_r  <= hiz1_r;
    plz2_r  <= PW'(lo2_nxt.n) * PW'(loz1_r.d);
    pzl2_r  <= PW'(loz1_r.n) * PW'(lo2_nxt.d);
    qhz2_r  <= PW'(hi2_nxt.n) * PW'(hiz1_r.d);
    qzh2_r  <= PW'(hiz1_r.n) * PW'(hi2_nxt.d);

    miss3_r <= miss2_r;
    seg3_r  <= seg2_r;
    lo3_r   <= lo3_nxt;
    plh3_r  <= PW'(lo3_nxt.n) * PW'(hi3_nxt.d);
    phl3_r  <= PW'(hi3_nxt.n) * PW'(lo3_nxt.d);

    hit4_r  <= !miss3_r && !(plh3_r > phl3_r);
    seg4_r  <= seg3_r;
    lo4_r   <= lo3_r;
  end

  assign out_v   = v4_r;
  assign out_hit = hit4_r;
  assign out_lo  = lo4_r;
  assign out_seg = seg4_r;

endmodule

// ----- hdl/sai_div.sv -----
`timescale 1ns / 1ps
module sai_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic          in_hit,
  input  sai_pkg::rat_t in_ratio,
  input  sai_pkg::in_t  in_seg,
  output logic          out_v,
  output logic          out_hit,
  output logic [16:0]   out_q,
  output sai_pkg::in_t  out_seg
);

  localparam int NS = sai_pkg::DIV_STAGES;
  localparam int RW = sai_pkg::DIV_RW;

  logic              v_r   [NS];
  logic              hit_r [NS];
  logic [RW-1:0]     rem_r [NS];
  logic [32:0]       d_r   [NS];
  logic [NS-1:0]     q_r   [NS];
  sai_pkg::in_t      seg_r [NS];

  logic              v_in   [NS];
  logic              hit_in [NS];
  logic [RW-1:0]     rem_in [NS];
  logic [32:0]       d_in   [NS];
  logic [NS-1:0]     q_in   [NS];
  sai_pkg::in_t      seg_in [NS];
  logic [RW-1:0]     sub    [NS];
  logic              ge     [NS];
  logic [RW-1:0]     dsh    [NS];

  // rounded quotient: (n * 2^16 + d/2) / d, one quotient bit per stage
  always_comb begin
    v_in[0]   = in_v;
    hit_in[0] = in_hit;
    rem_in[0] = {1'b0, in_ratio.n, 16'b0} + RW'(in_ratio.d >> 1);
    d_in[0]   = in_ratio.d;
    q_in[0]   = '0;
    seg_in[0] = in_seg;
    for (int k = 1; k < NS; k++) begin
      v_in[k]   = v_r[k-1];
      hit_in[k] = hit_r[k-1];
      rem_in[k] = rem_r[k-1];
      d_in[k]   = d_r[k-1];
      q_in[k]   = q_r[k-1];
      seg_in[k] = seg_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      dsh[k] = RW'(d_in[k]) << (NS - 1 - k);
      ge[k]  = rem_in[k] >= dsh[k];
      sub[k] = rem_in[k] - dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in[k];
      end
      hit_r[k] <= hit_in[k];
      rem_r[k] <= ge[k] ? sub[k] : rem_in[k];
      d_r[k]   <= d_in[k];
      q_r[k]   <= q_in[k] | (NS'(ge[k]) << (NS - 1 - k));
      seg_r[k] <= seg_in[k];
    end
  end

  assign out_v   = v_r[NS-1];
  assign out_hit = hit_r[NS-1];
  assign out_q   = q_r[NS-1];
  assign out_seg = seg_r[NS-1];

endmodule

// ----- hdl/sai_point.sv -----
`timescale 1ns / 1ps
module sai_point (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic          in_hit,
  input  logic [16:0]   in_t16,
  input  sai_pkg::in_t  in_seg,
  output logic          out_valid,
  output sai_pkg::out_t out_data
);

  logic               v_r, hit_r;
  logic [16:0]        t_r;
  logic signed [31:0] sx_r, sy_r, sz_r;
  logic signed [50:0] px_r, py_r, pz_r;
  logic               ov_r;
  sai_pkg::out_t      od_r;
  logic signed [50:0] tf;

  function automatic logic signed [31:0] step_pt(input logic signed [31:0] s,
                                                 input logic signed [50:0] p);
    logic signed [50:0] r;
    r = (p + 51'sd32768) >>> 16;
    return s + r[31:0];
  endfunction

  assign tf = $signed({34'b0, in_t16});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v_r  <= in_v;
      ov_r <= v_r;
    end
    hit_r <= in_hit;
    t_r   <= in_t16;
    sx_r  <= in_seg.start_x;
    sy_r  <= in_seg.start_y;
    sz_r  <= in_seg.start_z;
    px_r  <= (51'(in_seg.end_x) - 51'(in_seg.start_x)) * tf;
    py_r  <= (51'(in_seg.end_y) - 51'(in_seg.start_y)) * tf;
    pz_r  <= (51'(in_seg.end_z) - 51'(in_seg.start_z)) * tf;
    if (hit_r) begin
      od_r.hit            <= 1'b1;
      od_r.entry_fraction <= t_r;
      od_r.point_x        <= step_pt(sx_r, px_r);
      od_r.point_y        <= step_pt(sy_r, py_r);
      od_r.point_z        <= step_pt(sz_r, pz_r);
    end else begin
      od_r <= '0;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  sai_pkg::in_t  in_data = '0;
  logic          out_valid;
  sai_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  int errors = 0;

  always #1 clk = ~clk;

  segment_aabb_intersect_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  class hit_scoreboard;
    longint cx = 65536, cy = 65536, cz = 65536, hw = 65536;
    sai_pkg::out_t expected_hits[$];

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        sai_pkg::REG_CENTER_X: cx = longint'(signed'(v));
        sai_pkg::REG_CENTER_Y: cy = longint'(signed'(v));
        sai_pkg::REG_CENTER_Z: cz = longint'(signed'(v));
        sai_pkg::REG_HALF_WIDTH: hw = longint'({33'd0, v[30:0]});
        default: ;
      endcase
    endfunction

    function bit clip_slab(longint s, longint e, longint c,
                           ref longint unsigned ln, ref longint unsigned ld,
                           ref longint unsigned hn, ref longint unsigned hd);
      longint d, near_off, far_off, an, bn, den;
      longint unsigned ua, ub, ud;
      d = e - s;
      near_off = c - hw - s;
      far_off = c + hw - s;
      if (d == 0) return near_off <= 0 && far_off >= 0;
      if (d > 0) begin
        an = near_off; bn = far_off; den = d;
      end else begin
        an = -far_off; bn = -near_off; den = -d;
      end
      if (bn < 0) return 0;
      if (an > den) return 0;
      if (an < 0) an = 0;
      if (bn > den) bn = den;
      ua = an; ub = bn; ud = den;
      if (ub * ld < ln * ud) return 0;
      if (ua * hd > hn * ud) return 0;
      if (ua * ld > ln * ud) begin
        ln = ua; ld = ud;
      end
      if (ub * hd < hn * ud) begin
        hn = ub; hd = ud;
      end
      if (ln * hd > hn * ld) return 0;
      return 1;
    endfunction

    function logic [31:0] entry_coord(longint s, longint e, longint t16);
      longint p, q;
      p = (e - s) * t16 + 32768;
      if (p >= 0) q = p / 65536;
      else q = -((-p + 65535) / 65536);
      return 32'(s + q);
    endfunction

    function void note_segment(sai_pkg::in_t v);
      longint sx, sy, sz, ex, ey, ez, t16;
      longint unsigned ln, ld, hn, hd;
      sai_pkg::out_t r;
      sx = v.start_x; sy = v.start_y; sz = v.start_z;
      ex = v.end_x; ey = v.end_y; ez = v.end_z;
      ln = 0; ld = 1; hn = 1; hd = 1;
      r = '0;
      if (clip_slab(sx, ex, cx, ln, ld, hn, hd) && clip_slab(sy, ey, cy, ln, ld, hn, hd) &&
          clip_slab(sz, ez, cz, ln, ld, hn, hd)) begin
        t16 = longint'((ln * 65536 + ld / 2) / ld);
        r.hit = 1'b1;
        r.entry_fraction = 17'(t16);
        r.point_x = entry_coord(sx, ex, t16);
        r.point_y = entry_coord(sy, ey, t16);
        r.point_z = entry_coord(sz, ez, t16);
      end
      expected_hits.push_back(r);
    endfunction

    task check_result(sai_pkg::out_t got);
      sai_pkg::out_t w;
      if (expected_hits.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      w = expected_hits.pop_front();
      if (got.hit !== w.hit)
        report_mismatch($sformatf("hit %b exp %b", got.hit, w.hit));
      if (got.entry_fraction !== w.entry_fraction)
        report_mismatch($sformatf("entry_fraction %h exp %h",
                                  got.entry_fraction, w.entry_fraction));
      if (got.point_x !== w.point_x)
        report_mismatch($sformatf("point_x %h exp %h", got.point_x, w.point_x));
      if (got.point_y !== w.point_y)
        report_mismatch($sformatf("point_y %h exp %h", got.point_y, w.point_y));
      if (got.point_z !== w.point_z)
        report_mismatch($sformatf("point_z %h exp %h", got.point_z, w.point_z));
    endtask
  endclass

  hit_scoreboard sb = new();
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_data);
  end

  task automatic send_segment(sai_pkg::in_t v);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_data <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_segment(v);
    burst_left--;
    if (burst_left == 0) start <= 1'b0;
  endtask

  task automatic drain;
    if (burst_left != 0) start <= 1'b0;
    burst_left = 0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] near_box(longint c, longint h);
    longint span;
    span = 2 * h + 65536;
    return 32'(c + longint'($urandom_range(0, 32'hffff_ffff)) % span);
  endfunction

  function automatic sai_pkg::in_t seg(longint a, longint b, longint c, longint d,
                                       longint e, longint f);
    sai_pkg::in_t v;
    v.start_x = 32'(a); v.start_y = 32'(b); v.start_z = 32'(c);
    v.end_x = 32'(d); v.end_y = 32'(e); v.end_z = 32'(f);
    return v;
  endfunction

  task automatic random_segments(int n);
    sai_pkg::in_t v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        v.start_x = near_box(sb.cx, sb.hw);
        v.start_y = near_box(sb.cy, sb.hw);
        v.start_z = near_box(sb.cz, sb.hw);
        v.end_x = near_box(sb.cx, sb.hw);
        v.end_y = near_box(sb.cy, sb.hw);
        v.end_z = near_box(sb.cz, sb.hw);
        if ($urandom_range(0, 7) == 0) v.end_x = v.start_x;
        if ($urandom_range(0, 7) == 0) v.end_y = v.start_y;
        if ($urandom_range(0, 7) == 0) v.end_z = v.start_z;
      end
      send_segment(v);
    end
  endtask

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default box spans 0..2 on every axis
    send_segment(seg(-65536, 65536, 65536, 196608, 65536, 65536));
    send_segment(seg(196608, 65536, 65536, -65536, 65536, 65536));
    send_segment(seg(-65536, 196608, 65536, 196608, 196608, 65536));
    send_segment(seg(65536, 65536, 65536, 65536, 65536, 65536));
    send_segment(seg(0, 0, 0, 0, 0, 0));
    send_segment(seg(131072, 131072, 131072, 131072, 131072, 131072));
    send_segment(seg(131073, 65536, 65536, 131073, 65536, 65536));
    send_segment(seg(-131072, 0, 65536, 0, 0, 65536));
    send_segment(seg(-131072, 0, 65536, -1, 0, 65536));
    send_segment(seg(-131072, -131072, -131072, 262144, 262144, 262144));
    send_segment(seg(-65536, 196608, 65536, 196608, -65536, 65536));
    send_segment(seg(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647,
                     2147483647));
    send_segment(seg(2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
                     -2147483648));
    send_segment(seg(2147483647, 65536, 65536, -2147483648, 65536, 65536));
    send_segment(seg(-2147483648, 65536, 65536, -2147483648, 65536, 65536));
    send_segment(seg(65536, 65536, -65536, 65536, 65536, 65535));
    send_segment(seg(0, 1, 2, 3, 131072, 5));
    drain();

    write_reg(sai_pkg::REG_CENTER_X, 32'h7fff_ffff);
    write_reg(sai_pkg::REG_CENTER_Y, 32'h8000_0000);
    write_reg(sai_pkg::REG_CENTER_Z, 32'd0);
    write_reg(sai_pkg::REG_HALF_WIDTH, 32'hffff_ffff);
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_segment(seg(0, 0, 0, 0, 0, 0));
    send_segment(seg(-2147483648, 2147483647, -2147483648, 2147483647, -2147483648,
                     2147483647));
    random_segments(60);
    drain();

    write_reg(sai_pkg::REG_HALF_WIDTH, 32'd0);
    write_reg(sai_pkg::REG_CENTER_X, 32'd0);
    write_reg(sai_pkg::REG_CENTER_Y, 32'd0);
    send_segment(seg(-65536, -65536, -65536, 65536, 65536, 65536));
    send_segment(seg(0, 0, 0, 0, 0, 0));
    random_segments(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(sai_pkg::REG_CENTER_X, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
      write_reg(sai_pkg::REG_CENTER_Y, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
      write_reg(sai_pkg::REG_CENTER_Z, $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
      write_reg(sai_pkg::REG_HALF_WIDTH, $urandom_range(0, 32'h0004_0000));
      random_segments(45);
      drain();
      random_segments(45);
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
